/* hdl/f32exp_pkg.sv */
package f32exp_pkg;

   // exponent arithmetic inside the fused multiply-add
   typedef logic signed [11:0] exp_type;

   localparam logic [31:0] SignBit     = 32'h8000_0000;
   localparam logic [31:0] MagicBias   = 32'h4B40_0000;
   localparam logic [31:0] NegMagic    = 32'hCB40_0000;
   localparam logic [31:0] Log2eX32    = 32'h4238_AA3B;
   localparam logic [31:0] NegLn2Hi    = 32'hBCB1_7218;
   localparam logic [31:0] NegLn2Lo    = 32'h2E82_E308;
   localparam logic [31:0] CoefC1      = 32'h3F80_007B;
   localparam logic [31:0] CoefC2      = 32'h3F00_0000;
   localparam logic [31:0] OneBits     = 32'h3F80_0000;
   localparam logic [31:0] NegZero     = 32'h8000_0000;
   localparam logic [31:0] PlusInf     = 32'h7F80_0000;
   localparam logic [31:0] MinExponent = 32'hC100_0000;
   localparam logic [31:0] MaxExponent = 32'h3F80_0000;
   localparam logic [31:0] QuietBit    = 32'h0040_0000;
   // sortable keys of the +inf and zero cutoffs
   localparam logic [31:0] InfKey      = 32'hC2B1_7217;
   localparam logic [31:0] ZeroKey     = 32'h3D30_0E4B;

   // 2^(k/32), k = 0..31
   function automatic logic [31:0] pow2_frac(input logic [4:0] k);
      logic [31:0] v;
      case (k)
         5'd0:  v = 32'h3F800000;  5'd1:  v = 32'h3F82CD87;
         5'd2:  v = 32'h3F85AAC3;  5'd3:  v = 32'h3F88980F;
         5'd4:  v = 32'h3F8B95C2;  5'd5:  v = 32'h3F8EA43A;
         5'd6:  v = 32'h3F91C3D3;  5'd7:  v = 32'h3F94F4F0;
         5'd8:  v = 32'h3F9837F0;  5'd9:  v = 32'h3F9B8D3A;
         5'd10: v = 32'h3F9EF532;  5'd11: v = 32'h3FA27043;
         5'd12: v = 32'h3FA5FED7;  5'd13: v = 32'h3FA9A15B;
         5'd14: v = 32'h3FAD583F;  5'd15: v = 32'h3FB123F6;
         5'd16: v = 32'h3FB504F3;  5'd17: v = 32'h3FB8FBAF;
         5'd18: v = 32'h3FBD08A4;  5'd19: v = 32'h3FC12C4D;
         5'd20: v = 32'h3FC5672A;  5'd21: v = 32'h3FC9B9BE;
         5'd22: v = 32'h3FCE248C;  5'd23: v = 32'h3FD2A81E;
         5'd24: v = 32'h3FD744FD;  5'd25: v = 32'h3FDBFBB8;
         5'd26: v = 32'h3FE0CCDF;  5'd27: v = 32'h3FE5B907;
         5'd28: v = 32'h3FEAC0C7;  5'd29: v = 32'h3FEFE4BA;
         5'd30: v = 32'h3FF5257D;  default: v = 32'h3FFA83B3;
      endcase
      return v;
   endfunction

   // index of the highest set bit (priority encoder)
   function automatic logic [5:0] msb64(input logic [63:0] v);
      logic [5:0] p;
      p = '0;
      for (int i = 0; i < 64; i++) begin
         if (v[i]) p = 6'(i);
      end
      return p;
   endfunction

endpackage

/* hdl/float32_exp_table_poly_top.sv */
// Single-precision exp(x), streaming one item per clock while the output is not stalled.
//
// Input channel (req_): req_x_bits is a binary32 argument, req_last_item
// marks the end of a vector. An item is taken at a rising edge with
// req_valid high and req_stall low.
// Result channel (rsp_): rsp_exp_bits is exp(x) as binary32, rsp_last_out
// copies the last flag. An item leaves at an edge with rsp_valid high and
// rsp_stall low.
// Datapath: a chain of nine fused multiply-adds, eight deep, each a six-stage
// pipeline, plus an input and an output register. Throughput: one item per
// cycle while the output is not stalled.
// Stall: while a result waits at the output and rsp_stall is high, the whole
// pipeline holds and req_stall goes high, so no item is taken then; empty
// slots in the pipeline are not squeezed out.
// Reset: clears all valid bits; no item is in flight afterwards.
// NaN inputs give the quieted NaN, large inputs +inf, very negative +0.
module float32_exp_table_poly_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_x_bits,
   input  logic        req_last_item,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_exp_bits,
   output logic        rsp_last_out
);

   localparam int FmaLat = 6;
   localparam int TotLat = 8 * FmaLat;

   // advance the whole pipeline unless a finished item is held at the output
   logic en;
   logic rsp_valid_ff;
   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;

   // input register
   logic        valid_ff;
   logic [31:0] x_ff;
   logic        last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff    <= req_x_bits;
         last_ff <= req_last_item;
      end
   end

   // special arguments: NaN, above the +inf cutoff, below the zero cutoff
   logic [31:0] key;
   logic        spec;
   logic [31:0] sval;

   always_comb begin
      key = x_ff[31] ? ~x_ff : (x_ff | f32exp_pkg::SignBit);
      spec = 1'b1;
      if (x_ff[30:0] > f32exp_pkg::PlusInf[30:0]) begin
         sval = x_ff | f32exp_pkg::QuietBit;
      end else if (key > f32exp_pkg::InfKey) begin
         sval = f32exp_pkg::PlusInf;
      end else if (key < f32exp_pkg::ZeroKey) begin
         sval = 32'd0;
      end else begin
         spec = 1'b0;
         sval = 32'd0;
      end
   end

   // side lines that travel with the arithmetic
   logic        vld_dly_ff  [TotLat];
   logic        spec_dly_ff [TotLat];
   logic [31:0] sval_dly_ff [TotLat];
   logic        last_dly_ff [TotLat];
   logic [31:0] x_dly_ff    [2 * FmaLat];
   logic [31:0] n_dly_ff    [FmaLat];
   logic [31:0] l_dly_ff    [4 * FmaLat];
   logic [31:0] sn_dly_ff   [5 * FmaLat];
   logic [31:0] so_dly_ff   [6 * FmaLat];

   logic [31:0] nb, n, t1, t2, p, t3, f, fs, fo;
   logic [31:0] e_o, e_n, e_r, sn, so, l;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TotLat; i++) vld_dly_ff[i] <= 1'b0;
      end else if (en) begin
         vld_dly_ff[0] <= valid_ff;
         for (int i = 1; i < TotLat; i++) vld_dly_ff[i] <= vld_dly_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         spec_dly_ff[0] <= spec;
         sval_dly_ff[0] <= sval;
         last_dly_ff[0] <= last_ff;
         for (int i = 1; i < TotLat; i++) begin
            spec_dly_ff[i] <= spec_dly_ff[i-1];
            sval_dly_ff[i] <= sval_dly_ff[i-1];
            last_dly_ff[i] <= last_dly_ff[i-1];
         end
         x_dly_ff[0] <= x_ff;
         for (int i = 1; i < 2 * FmaLat; i++) x_dly_ff[i] <= x_dly_ff[i-1];
         n_dly_ff[0] <= n;
         for (int i = 1; i < FmaLat; i++) n_dly_ff[i] <= n_dly_ff[i-1];
         l_dly_ff[0] <= l;
         for (int i = 1; i < 4 * FmaLat; i++) l_dly_ff[i] <= l_dly_ff[i-1];
         sn_dly_ff[0] <= sn;
         for (int i = 1; i < 5 * FmaLat; i++) sn_dly_ff[i] <= sn_dly_ff[i-1];
         so_dly_ff[0] <= so;
         for (int i = 1; i < 6 * FmaLat; i++) so_dly_ff[i] <= so_dly_ff[i-1];
      end
   end

   // n = round(x * 32/ln2) via magic bias
   f32exp_fma u_nb (.clock, .en, .a_bits(x_ff), .b_bits(f32exp_pkg::Log2eX32),
                    .c_bits(f32exp_pkg::MagicBias), .y_bits(nb));

   // split the integer part of n into two scale exponents; table by low bits
   always_comb begin
      e_o = {nb[13:5], 23'b0};
      e_n = ($signed(e_o) > $signed(f32exp_pkg::MinExponent)) ? e_o
            : f32exp_pkg::MinExponent;
      if ($signed(e_n) > $signed(f32exp_pkg::MaxExponent)) begin
         e_n = f32exp_pkg::MaxExponent;
      end
      e_r = e_o - e_n;
      sn  = e_n + f32exp_pkg::MaxExponent;
      so  = e_r + f32exp_pkg::MaxExponent;
      l   = f32exp_pkg::pow2_frac(nb[4:0]);
   end

   f32exp_fma u_n  (.clock, .en, .a_bits(nb), .b_bits(f32exp_pkg::OneBits),
                    .c_bits(f32exp_pkg::NegMagic), .y_bits(n));
   // Cody-Waite reduction: t = x - n*ln2/32 in two pieces
   f32exp_fma u_t1 (.clock, .en, .a_bits(n), .b_bits(f32exp_pkg::NegLn2Hi),
                    .c_bits(x_dly_ff[2*FmaLat-1]), .y_bits(t1));
   f32exp_fma u_t2 (.clock, .en, .a_bits(n_dly_ff[FmaLat-1]),
                    .b_bits(f32exp_pkg::NegLn2Lo), .c_bits(t1), .y_bits(t2));
   // polynomial c1 + t*c2, and l*t, side by side
   f32exp_fma u_p  (.clock, .en, .a_bits(t2), .b_bits(f32exp_pkg::CoefC2),
                    .c_bits(f32exp_pkg::CoefC1), .y_bits(p));
   f32exp_fma u_t3 (.clock, .en, .a_bits(t2), .b_bits(l_dly_ff[3*FmaLat-1]),
                    .c_bits(f32exp_pkg::NegZero), .y_bits(t3));
   f32exp_fma u_f  (.clock, .en, .a_bits(t3), .b_bits(p),
                    .c_bits(l_dly_ff[4*FmaLat-1]), .y_bits(f));
   // scale by two powers of two so subnormal results come out right
   f32exp_fma u_fs (.clock, .en, .a_bits(f), .b_bits(sn_dly_ff[5*FmaLat-1]),
                    .c_bits(f32exp_pkg::NegZero), .y_bits(fs));
   f32exp_fma u_fo (.clock, .en, .a_bits(so_dly_ff[6*FmaLat-1]), .b_bits(fs),
                    .c_bits(f32exp_pkg::NegZero), .y_bits(fo));

   // output register: pick the special result or the computed one
   logic [31:0] rsp_exp_bits_ff;
   logic        rsp_last_out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= vld_dly_ff[TotLat-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_exp_bits_ff <= spec_dly_ff[TotLat-1] ? sval_dly_ff[TotLat-1] : fo;
         rsp_last_out_ff <= last_dly_ff[TotLat-1];
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_exp_bits = rsp_exp_bits_ff;
   assign rsp_last_out = rsp_last_out_ff;

endmodule

/* hdl/f32exp_fma.sv */
// Binary32 fused multiply-add a*b + c, single rounding to nearest even,
// subnormals kept. Six register stages; y_bits is registered.
module f32exp_fma (
   input  logic        clock,
   input  logic        en,
   input  logic [31:0] a_bits,
   input  logic [31:0] b_bits,
   input  logic [31:0] c_bits,
   output logic [31:0] y_bits
);

   // stage 1: unpack and multiply
   logic [47:0]          mp_ff;
   f32exp_pkg::exp_type  ep_ff, ec_ff;
   logic [23:0]          mc_ff;
   logic                 sp_ff, sc_ff;
   logic [31:0]          c1_ff;

   logic [23:0]          ma, mb, mc;
   f32exp_pkg::exp_type  ea, eb, ec;

   always_comb begin
      ma = {(a_bits[30:23] != 8'd0), a_bits[22:0]};
      mb = {(b_bits[30:23] != 8'd0), b_bits[22:0]};
      mc = {(c_bits[30:23] != 8'd0), c_bits[22:0]};
      ea = $signed({4'b0, (a_bits[30:23] == 8'd0) ? 8'd1 : a_bits[30:23]}) - 12'sd150;
      eb = $signed({4'b0, (b_bits[30:23] == 8'd0) ? 8'd1 : b_bits[30:23]}) - 12'sd150;
      ec = $signed({4'b0, (c_bits[30:23] == 8'd0) ? 8'd1 : c_bits[30:23]}) - 12'sd150;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mp_ff <= ma * mb;
         ep_ff <= ea + eb;
         mc_ff <= mc;
         ec_ff <= ec;
         sp_ff <= a_bits[31] ^ b_bits[31];
         sc_ff <= c_bits[31];
         c1_ff <= c_bits;
      end
   end

   // stage 2: normalize both terms to bit 61, order by exponent
   logic [63:0]          big2_ff, sml2_ff;
   f32exp_pkg::exp_type  ebig2_ff, d2_ff;
   logic                 sbig2_ff, ssml2_ff, spec2_ff;
   logic [31:0]          sval2_ff;

   logic [5:0]           shm, shc;
   logic [63:0]          mpn, mcn;
   f32exp_pkg::exp_type  epn, ecn;
   logic [63:0]          big_in, sml_in;
   f32exp_pkg::exp_type  ebig_in, esml_in;
   logic                 sbig_in, ssml_in, spec_in;
   logic [31:0]          sval_in;

   always_comb begin
      shm = 6'd61 - f32exp_pkg::msb64({16'b0, mp_ff});
      shc = 6'd61 - f32exp_pkg::msb64({40'b0, mc_ff});
      mpn = {16'b0, mp_ff} << shm;
      mcn = {40'b0, mc_ff} << shc;
      epn = ep_ff - $signed({6'b0, shm});
      ecn = ec_ff - $signed({6'b0, shc});
      if (mc_ff == 24'd0 || epn >= ecn) begin
         big_in = mpn; ebig_in = epn; sbig_in = sp_ff;
         sml_in = (mc_ff == 24'd0) ? 64'd0 : mcn;
         esml_in = (mc_ff == 24'd0) ? epn : ecn;
         ssml_in = sc_ff;
      end else begin
         big_in = mcn; ebig_in = ecn; sbig_in = sc_ff;
         sml_in = mpn; esml_in = epn; ssml_in = sp_ff;
      end
      // zero product: result is c, or a signed zero
      spec_in = (mp_ff == 48'd0);
      if (mc_ff == 24'd0) begin
         sval_in = (sp_ff == sc_ff) ? {sp_ff, 31'b0} : 32'd0;
      end else begin
         sval_in = c1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         big2_ff  <= big_in;
         sml2_ff  <= sml_in;
         ebig2_ff <= ebig_in;
         d2_ff    <= ebig_in - esml_in;
         sbig2_ff <= sbig_in;
         ssml2_ff <= ssml_in;
         spec2_ff <= spec_in;
         sval2_ff <= sval_in;
      end
   end

   // stage 3: align the smaller term, keep a sticky bit
   logic [63:0]          big3_ff, sml3_ff;
   f32exp_pkg::exp_type  ebig3_ff;
   logic                 sbig3_ff, ssml3_ff, spec3_ff;
   logic [31:0]          sval3_ff;

   logic [63:0]          sml_al;
   logic [5:0]           dd;

   always_comb begin
      dd = d2_ff[5:0];
      if (d2_ff >= 12'sd63) begin
         sml_al = {63'b0, (sml2_ff != 64'd0)};
      end else begin
         sml_al = (sml2_ff >> dd)
                | {63'b0, ((sml2_ff & ~({64{1'b1}} << dd)) != 64'd0)};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         big3_ff  <= big2_ff;
         sml3_ff  <= sml_al;
         ebig3_ff <= ebig2_ff;
         sbig3_ff <= sbig2_ff;
         ssml3_ff <= ssml2_ff;
         spec3_ff <= spec2_ff;
         sval3_ff <= sval2_ff;
      end
   end

   // stage 4: add or subtract magnitudes
   logic [63:0]          r4_ff;
   f32exp_pkg::exp_type  e4_ff;
   logic                 s4_ff, spec4_ff;
   logic [31:0]          sval4_ff;

   logic [63:0]          r_in;
   logic                 s_in, zero_in;

   always_comb begin
      zero_in = 1'b0;
      if (sbig3_ff == ssml3_ff) begin
         r_in = big3_ff + sml3_ff;
         s_in = sbig3_ff;
      end else if (big3_ff > sml3_ff) begin
         r_in = big3_ff - sml3_ff;
         s_in = sbig3_ff;
      end else begin
         r_in = sml3_ff - big3_ff;
         s_in = ssml3_ff;
         zero_in = (sml3_ff == big3_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r4_ff    <= r_in;
         e4_ff    <= ebig3_ff;
         s4_ff    <= s_in;
         spec4_ff <= spec3_ff | zero_in;
         sval4_ff <= spec3_ff ? sval3_ff : 32'd0;
      end
   end

   // stage 5: find the leading one, shift to 24 bits or to the subnormal floor
   logic [23:0]          q5_ff;
   logic                 g5_ff, st5_ff, s5_ff, spec5_ff;
   f32exp_pkg::exp_type  e5_ff;
   logic [31:0]          sval5_ff;

   f32exp_pkg::exp_type  sh, lim, negsh;
   logic [127:0]         wide;
   logic [6:0]           rs;
   logic [23:0]          q_in;
   logic                 g_in, st_in;

   always_comb begin
      sh    = $signed({6'b0, f32exp_pkg::msb64(r4_ff)}) - 12'sd23;
      lim   = -12'sd149 - e4_ff;
      if (lim > sh) sh = lim;
      negsh = -sh;
      rs    = (sh > 12'sd127) ? 7'd127 : sh[6:0];
      wide  = {r4_ff, 64'b0} >> rs;
      if (sh <= 12'sd0) begin
         q_in  = r4_ff[23:0] << negsh[4:0];
         g_in  = 1'b0;
         st_in = 1'b0;
      end else begin
         q_in  = wide[87:64];
         g_in  = wide[63];
         st_in = (wide[62:0] != 63'd0);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         q5_ff    <= q_in;
         g5_ff    <= g_in;
         st5_ff   <= st_in;
         e5_ff    <= e4_ff + sh;
         s5_ff    <= s4_ff;
         spec5_ff <= spec4_ff;
         sval5_ff <= sval4_ff;
      end
   end

   // stage 6: round to nearest even and pack
   logic [24:0]          q2;
   logic [23:0]          qf;
   f32exp_pkg::exp_type  ef, bexp;
   logic [31:0]          packed_val;
   logic [31:0]          y_ff;

   always_comb begin
      q2 = {1'b0, q5_ff} + {24'b0, (g5_ff & (st5_ff | q5_ff[0]))};
      if (q2[24]) begin
         qf = q2[24:1];
         ef = e5_ff + 12'sd1;
      end else begin
         qf = q2[23:0];
         ef = e5_ff;
      end
      bexp = ef + 12'sd150;
      if (!qf[23]) begin
         packed_val = {s5_ff, 8'b0, qf[22:0]};
      end else if (bexp >= 12'sd255) begin
         packed_val = {s5_ff, f32exp_pkg::PlusInf[30:0]};
      end else begin
         packed_val = {s5_ff, bexp[7:0], qf[22:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         y_ff <= spec5_ff ? sval5_ff : packed_val;
      end
   end

   assign y_bits = y_ff;

endmodule
